// ----- rtl/ics_pkg.sv -----
`timescale 1ns / 1ps

package ics_pkg;

    localparam int DefaultDepthBits = 8;
    localparam int DepthFieldBits = 8;
    localparam int ModeBits = 3;
    localparam int OutDataBits = 32;

    typedef enum logic [ModeBits-1:0] {
        MODE_NORMAL = 3'd0,
        MODE_LINE   = 3'd1,
        MODE_BLOCK  = 3'd2,
        MODE_SINGLE = 3'd3,
        MODE_DOUBLE = 3'd4,
        MODE_RAW    = 3'd5
    } lex_mode_t;

    localparam logic [7:0] ChHash      = 8'h23;
    localparam logic [7:0] ChTilde     = 8'h7E;
    localparam logic [7:0] ChBacktick  = 8'h60;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChSingle    = 8'h27;
    localparam logic [7:0] ChDouble    = 8'h22;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChRoundOpen   = 8'h28;
    localparam logic [7:0] ChRoundClose  = 8'h29;
    localparam logic [7:0] ChSquareOpen  = 8'h5B;
    localparam logic [7:0] ChSquareClose = 8'h5D;
    localparam logic [7:0] ChCurlyOpen   = 8'h7B;
    localparam logic [7:0] ChCurlyClose  = 8'h7D;

endpackage

// ----- rtl/input_completeness_scanner.sv -----
`timescale 1ns / 1ps

// Scans source text one byte per beat and reports, for every byte, whether the text so far
// still needs more input, the round, square and curly bracket depths and the lexical mode.
// A byte is registered on input and its result is registered on output, and a new byte is
// taken every cycle while the output is not stalled; the loop through the mode and depth
// registers sets that rate. A beat with s_tuser set clears all scanner state before its byte.
// Depth counters are DEPTH_BITS wide, saturate at their maximum and ignore closers at zero;
// each depth field carries the low 8 bits of its counter.
module input_completeness_scanner #(
    parameter int DEPTH_BITS = ics_pkg::DefaultDepthBits
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] text_byte
    input  logic                          s_tuser,   // [0] first_of_text
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] needs_more, [8:1] round_depth, [16:9] square_depth, [24:17] curly_depth,
    // [27:25] lex_mode, [31:28] zero
    output logic [ics_pkg::OutDataBits-1:0] m_tdata
);
    import ics_pkg::*;

    localparam int ExtBits = (DEPTH_BITS > DepthFieldBits) ? DEPTH_BITS : DepthFieldBits;
    localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_first_reg;
    logic                  out_valid_reg;
    logic [OutDataBits-1:0] out_data_reg;
    logic [OutDataBits-1:0] out_data_next;

    lex_mode_t             mode_reg, mode_next;
    logic                  escape_reg, escape_next;
    logic [DEPTH_BITS-1:0] round_reg, round_next;
    logic [DEPTH_BITS-1:0] square_reg, square_next;
    logic [DEPTH_BITS-1:0] curly_reg, curly_next;

    lex_mode_t             mode_base;
    logic                  escape_base;
    logic [DEPTH_BITS-1:0] round_base, square_base, curly_base;
    logic                  move;
    logic                  needs_more;
    logic [ExtBits-1:0]    round_ext, square_ext, curly_ext;
    logic [7:0]            quote_closer;

    assign move = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    always_comb
    begin
        mode_base = in_first_reg ? MODE_NORMAL : mode_reg;
        escape_base = in_first_reg ? 1'b0 : escape_reg;
        round_base = in_first_reg ? '0 : round_reg;
        square_base = in_first_reg ? '0 : square_reg;
        curly_base = in_first_reg ? '0 : curly_reg;

        mode_next = mode_base;
        escape_next = escape_base;
        round_next = round_base;
        square_next = square_base;
        curly_next = curly_base;
        quote_closer = (mode_base == MODE_SINGLE) ? ChSingle : ChDouble;

        case (mode_base)
            MODE_LINE:
            begin
                if (in_byte_reg == ChNewline)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_BLOCK:
            begin
                if (in_byte_reg == ChTilde)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_RAW:
            begin
                if (in_byte_reg == ChBacktick)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_SINGLE, MODE_DOUBLE:
            begin
                if (escape_base)
                begin
                    escape_next = 1'b0;
                end
                else if (in_byte_reg == ChBackslash)
                begin
                    escape_next = 1'b1;
                end
                else if (in_byte_reg == quote_closer)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            default:
            begin
                case (in_byte_reg)
                    ChHash:      mode_next = MODE_LINE;
                    ChTilde:     mode_next = MODE_BLOCK;
                    ChBacktick:  mode_next = MODE_RAW;
                    ChSingle:
                    begin
                        mode_next = MODE_SINGLE;
                        escape_next = 1'b0;
                    end
                    ChDouble:
                    begin
                        mode_next = MODE_DOUBLE;
                        escape_next = 1'b0;
                    end
                    ChRoundOpen:
                    begin
                        if (round_base != DepthMax) round_next = round_base + 1'b1;
                    end
                    ChRoundClose:
                    begin
                        if (round_base != '0) round_next = round_base - 1'b1;
                    end
                    ChSquareOpen:
                    begin
                        if (square_base != DepthMax) square_next = square_base + 1'b1;
                    end
                    ChSquareClose:
                    begin
                        if (square_base != '0) square_next = square_base - 1'b1;
                    end
                    ChCurlyOpen:
                    begin
                        if (curly_base != DepthMax) curly_next = curly_base + 1'b1;
                    end
                    ChCurlyClose:
                    begin
                        if (curly_base != '0) curly_next = curly_base - 1'b1;
                    end
                    default:     mode_next = MODE_NORMAL;
                endcase
            end
        endcase

        needs_more = (round_next != '0) || (square_next != '0) || (curly_next != '0) ||
                     (mode_next == MODE_BLOCK) || (mode_next == MODE_SINGLE) ||
                     (mode_next == MODE_DOUBLE) || (mode_next == MODE_RAW);

        round_ext = ExtBits'(round_next);
        square_ext = ExtBits'(square_next);
        curly_ext = ExtBits'(curly_next);

        out_data_next = '0;
        out_data_next[0] = needs_more;
        out_data_next[8:1] = round_ext[7:0];
        out_data_next[16:9] = square_ext[7:0];
        out_data_next[24:17] = curly_ext[7:0];
        out_data_next[27:25] = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg <= MODE_NORMAL;
            escape_reg <= 1'b0;
            round_reg <= '0;
            square_reg <= '0;
            curly_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
                mode_reg <= mode_next;
                escape_reg <= escape_next;
                round_reg <= round_next;
                square_reg <= square_next;
                curly_reg <= curly_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_first_reg <= s_tuser;
        end
        if (move)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- test/tb_input_completeness_scanner.sv -----
`timescale 1ns / 1ps

module tb_input_completeness_scanner;
    import ics_pkg::*;

    localparam int DepthBits = DefaultDepthBits;
    localparam int WatchdogLimit = 5000;
    localparam int PhaseBytes = 50;
    localparam int SaturationRun = (1 << DepthBits) + 4;

    typedef struct {
        logic                      needs_more;
        logic [DepthFieldBits-1:0] round_depth;
        logic [DepthFieldBits-1:0] square_depth;
        logic [DepthFieldBits-1:0] curly_depth;
        lex_mode_t                 lex_mode;
    } scan_result_t;

    class scan_scoreboard;
        lex_mode_t          mode;
        bit                 escape;
        bit [DepthBits-1:0] round_cnt;
        bit [DepthBits-1:0] square_cnt;
        bit [DepthBits-1:0] curly_cnt;
        scan_result_t       expected_q[$];
        int unsigned        mismatches;
        int unsigned        results_checked;
        int unsigned        needs_more_seen;
        int unsigned        saturated_seen;

        function new();
            clear_state();
        endfunction

        function void clear_state();
            mode = MODE_NORMAL;
            escape = 1'b0;
            round_cnt = '0;
            square_cnt = '0;
            curly_cnt = '0;
        endfunction

        function void quoted_byte(logic [7:0] b, logic [7:0] closer);
            if (escape)
                escape = 1'b0;
            else if (b == ChBackslash)
                escape = 1'b1;
            else if (b == closer)
                mode = MODE_NORMAL;
        endfunction

        function void normal_byte(logic [7:0] b);
            case (b)
                ChHash:        mode = MODE_LINE;
                ChTilde:       mode = MODE_BLOCK;
                ChSingle:
                begin
                    mode = MODE_SINGLE;
                    escape = 1'b0;
                end
                ChDouble:
                begin
                    mode = MODE_DOUBLE;
                    escape = 1'b0;
                end
                ChBacktick:    mode = MODE_RAW;
                ChRoundOpen:   if (round_cnt != '1) round_cnt++;
                ChRoundClose:  if (round_cnt != '0) round_cnt--;
                ChSquareOpen:  if (square_cnt != '1) square_cnt++;
                ChSquareClose: if (square_cnt != '0) square_cnt--;
                ChCurlyOpen:   if (curly_cnt != '1) curly_cnt++;
                ChCurlyClose:  if (curly_cnt != '0) curly_cnt--;
                default:       mode = MODE_NORMAL;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic first);
            scan_result_t want;
            if (first)
                clear_state();
            case (mode)
                MODE_LINE:   if (b == ChNewline) mode = MODE_NORMAL;
                MODE_BLOCK:  if (b == ChTilde) mode = MODE_NORMAL;
                MODE_SINGLE: quoted_byte(b, ChSingle);
                MODE_DOUBLE: quoted_byte(b, ChDouble);
                MODE_RAW:    if (b == ChBacktick) mode = MODE_NORMAL;
                default:     normal_byte(b);
            endcase
            want.needs_more = (round_cnt != '0) || (square_cnt != '0) || (curly_cnt != '0) ||
                              (mode == MODE_BLOCK) || (mode == MODE_SINGLE) ||
                              (mode == MODE_DOUBLE) || (mode == MODE_RAW);
            want.round_depth = DepthFieldBits'(round_cnt);
            want.square_depth = DepthFieldBits'(square_cnt);
            want.curly_depth = DepthFieldBits'(curly_cnt);
            want.lex_mode = mode;
            if (want.needs_more)
                needs_more_seen++;
            if (round_cnt == '1 || square_cnt == '1 || curly_cnt == '1)
                saturated_seen++;
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("%0t ns: result %0d %s: got %0h, expected %0h",
                     $time, results_checked, field, got, want);
        endtask

        task check_result(logic [31:0] beat);
            scan_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("beat with nothing outstanding", beat, '0);
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (beat[0] !== want.needs_more)
                report_mismatch("needs_more", beat[0], want.needs_more);
            if (beat[8:1] !== want.round_depth)
                report_mismatch("round_depth", beat[8:1], want.round_depth);
            if (beat[16:9] !== want.square_depth)
                report_mismatch("square_depth", beat[16:9], want.square_depth);
            if (beat[24:17] !== want.curly_depth)
                report_mismatch("curly_depth", beat[24:17], want.curly_depth);
            if (beat[27:25] !== want.lex_mode)
                report_mismatch("lex_mode", beat[27:25], want.lex_mode);
            if (beat[31:28] !== 4'd0)
                report_mismatch("padding", beat[31:28], '0);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned texts_sent = 0;
    int unsigned quiet_cycles = 0;

    scan_scoreboard sb = new();

    input_completeness_scanner uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_byte(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("%0t ns: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("tb_input_completeness_scanner: FAIL");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] text_byte, input logic first_of_text);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = text_byte;
        s_tuser = first_of_text;
        if (first_of_text)
            texts_sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(19))
            0, 1:   return ChRoundOpen;
            2:      return ChRoundClose;
            3:      return ChSquareOpen;
            4:      return ChSquareClose;
            5:      return ChCurlyOpen;
            6:      return ChCurlyClose;
            7:      return ChHash;
            8:      return ChTilde;
            9:      return ChSingle;
            10:     return ChDouble;
            11:     return ChBacktick;
            12, 13: return ChBackslash;
            14:     return ChNewline;
            15:     return 8'h61 + 8'($urandom_range(25));
            16:     return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Walks the predicted state back to a complete text, so that needs_more falls again.
    task automatic close_text();
        while (sb.mode != MODE_NORMAL)
        begin
            case (sb.mode)
                MODE_LINE:   send_beat(ChNewline, 1'b0);
                MODE_BLOCK:  send_beat(ChTilde, 1'b0);
                MODE_SINGLE: send_beat(ChSingle, 1'b0);
                MODE_DOUBLE: send_beat(ChDouble, 1'b0);
                default:     send_beat(ChBacktick, 1'b0);
            endcase
        end
        while (sb.round_cnt != '0)
            send_beat(ChRoundClose, 1'b0);
        while (sb.square_cnt != '0)
            send_beat(ChSquareClose, 1'b0);
        while (sb.curly_cnt != '0)
            send_beat(ChCurlyClose, 1'b0);
    endtask

    task automatic run_phase(input int unsigned idle_in, input int unsigned idle_out);
        int unsigned stop_at;
        int unsigned text_len;
        stop_at = bytes_sent + PhaseBytes;
        send_idle_pct = idle_in;
        stall_pct = idle_out;
        while (bytes_sent < stop_at)
        begin
            text_len = $urandom_range(40, 1);
            send_beat(pick_text_byte(), 1'b1);
            for (int i = 1; i < text_len; i++)
                send_beat(pick_text_byte(), ($urandom_range(99) < 2));
            if ($urandom_range(99) < 60)
                close_text();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_beat(8'h00, 1'b1);
        send_beat(ChRoundClose, 1'b0);
        send_beat(ChSquareClose, 1'b0);
        send_beat(ChCurlyClose, 1'b0);
        send_beat(ChRoundOpen, 1'b0);
        send_beat(ChSquareOpen, 1'b0);
        send_beat(ChCurlyOpen, 1'b0);
        send_beat(ChHash, 1'b1);
        send_beat(ChRoundOpen, 1'b0);
        send_beat(ChNewline, 1'b0);
        send_beat(ChTilde, 1'b0);
        send_beat(ChRoundClose, 1'b0);
        send_beat(ChTilde, 1'b0);
        send_beat(ChSingle, 1'b0);
        send_beat(ChBackslash, 1'b0);
        send_beat(ChSingle, 1'b0);
        send_beat(ChSingle, 1'b0);
        send_beat(ChDouble, 1'b0);
        send_beat(ChBackslash, 1'b0);
        send_beat(ChBackslash, 1'b0);
        send_beat(ChDouble, 1'b0);
        send_beat(ChBacktick, 1'b0);
        send_beat(ChBackslash, 1'b0);
        send_beat(ChBacktick, 1'b0);
        send_beat(8'hFF, 1'b1);

        send_beat(ChRoundOpen, 1'b1);
        for (int i = 1; i < SaturationRun; i++)
            send_beat(ChRoundOpen, 1'b0);
        for (int i = 0; i < SaturationRun; i++)
            send_beat(ChSquareOpen, 1'b0);
        for (int i = 0; i < SaturationRun; i++)
            send_beat(ChCurlyOpen, 1'b0);
        send_beat(ChRoundClose, 1'b0);
        send_beat(ChSquareClose, 1'b0);
        send_beat(ChCurlyClose, 1'b0);

        run_phase(0, 0);
        run_phase(71, 0);
        run_phase(0, 71);
        run_phase(15, 15);

        s_tvalid = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Scanned %0d bytes in %0d texts under four handshake patterns,",
                 bytes_sent, texts_sent);
        $display("%0d results open, %0d saturated; checked %0d results, %0d mismatches.",
                 sb.needs_more_seen, sb.saturated_seen, sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_input_completeness_scanner: PASS");
        else
            $display("tb_input_completeness_scanner: FAIL");
        $finish;
    end

endmodule
